/* sv/rvl_depth_decoder_core_defines.svh */
// Assertion macros for the depth decoder RTL.
`ifndef RVL_DEPTH_DECODER_CORE_DEFINES_SVH
`define RVL_DEPTH_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RVL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RVL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rvl_pkg.sv */
// Shared types and constants of the depth decoder.
package rvl_pkg;

  localparam int WORD_W   = 32;
  localparam int NIB_W    = 4;
  localparam int DIGIT_W  = 3;
  localparam int NIBBLES  = 8;
  localparam int NCNT_W   = 4;
  localparam int POS_W    = 4;
  localparam int ACC_SPAN = DIGIT_W * (2 ** POS_W);
  localparam int PIX_W    = 24;
  localparam int VALUE_W  = 16;

  localparam int COUNT_BITS_DEF = 24;

  localparam logic [PIX_W-1:0]  PIXEL_COUNT_RST = PIX_W'(307200);
  localparam logic [POS_W-1:0]  POS_MAX         = '1;
  localparam logic [NCNT_W-1:0] NIB_FULL        = NCNT_W'(NIBBLES);

  // One run descriptor, minus the end-of-word mark.
  typedef struct packed {
    logic [VALUE_W-1:0] pixel_value;
    logic [PIX_W-1:0]   repeat_count;
    logic               frame_done;
    logic               format_error;
  } res_t;

  // What the run decoder reports for one nibble.
  typedef struct packed {
    logic emit;
    logic ended;
    res_t res;
  } dec_out_t;

endpackage

/* sv/rvl_nibble_sreg.sv */
// Word shift register: hands out one nibble per cycle while shift is high, top nibble first.
module rvl_nibble_sreg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [rvl_pkg::WORD_W-1:0]        word,
  input  logic                              shift,
  input  logic                              flush,
  output logic [rvl_pkg::NIB_W-1:0]         nibble,
  output logic                              avail
);

  logic [rvl_pkg::WORD_W-1:0] sreg;
  logic [rvl_pkg::NCNT_W-1:0] left;

  assign nibble = sreg[rvl_pkg::WORD_W-1 -: rvl_pkg::NIB_W];
  assign avail  = (left != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load) begin
      left <= rvl_pkg::NIB_FULL;
    end else if (flush) begin
      left <= '0;
    end else if (shift) begin
      left <= left - rvl_pkg::NCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sreg <= word;
    end else if (shift) begin
      sreg <= {sreg[rvl_pkg::WORD_W-rvl_pkg::NIB_W-1:0], rvl_pkg::NIB_W'(0)};
    end
  end

endmodule

/* sv/rvl_value_asm.sv */
// Builds one variable-length value from 3-bit digits, lowest digit first.
module rvl_value_asm #(
  parameter int COUNT_BITS = rvl_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       fire,
  input  logic [rvl_pkg::NIB_W-1:0]  nibble,
  output logic [COUNT_BITS-1:0]      val,
  output logic                       done,
  output logic                       ovf
);

  logic [COUNT_BITS-1:0]        acc;
  logic [rvl_pkg::POS_W-1:0]    pos;
  logic [5:0]                   sh;
  logic [rvl_pkg::ACC_SPAN-1:0] placed;

  always_comb begin
    sh     = 6'(pos) * 6'd3;
    placed = rvl_pkg::ACC_SPAN'(nibble[rvl_pkg::DIGIT_W-1:0]) << sh;
  end

  assign val  = acc | placed[COUNT_BITS-1:0];
  assign ovf  = |placed[rvl_pkg::ACC_SPAN-1:COUNT_BITS];
  assign done = !nibble[rvl_pkg::NIB_W-1];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
      pos <= '0;
    end else if (fire) begin
      if (done) begin
        acc <= '0;
        pos <= '0;
      end else begin
        acc <= val;
        // position saturates so very long values keep dropping high bits
        if (pos != rvl_pkg::POS_MAX) begin
          pos <= pos + rvl_pkg::POS_W'(1);
        end
      end
    end
  end

endmodule

/* sv/rvl_run_decode.sv */
// Run decoder: zero-run count, nonzero-run count, zigzag deltas; frame bookkeeping.
module rvl_run_decode #(
  parameter int COUNT_BITS = rvl_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [rvl_pkg::PIX_W-1:0]   cfg_wdata,
  input  logic                        fire,
  input  logic                        val_done,
  input  logic [COUNT_BITS-1:0]       val,
  input  logic                        ovf,
  output rvl_pkg::dec_out_t           dec
);

  localparam int CW = (COUNT_BITS > rvl_pkg::PIX_W) ? COUNT_BITS : rvl_pkg::PIX_W;

  typedef enum logic [2:0] {
    PH_ZERO  = 3'b001,
    PH_NZ    = 3'b010,
    PH_DELTA = 3'b100
  } phase_t;

  phase_t                        phase, phase_next;
  logic [rvl_pkg::PIX_W-1:0]     pixel_count;
  logic [rvl_pkg::PIX_W-1:0]     pixels_left, pixels_left_next;
  logic [rvl_pkg::PIX_W-1:0]     nz_left, nz_left_next;
  logic [rvl_pkg::VALUE_W-1:0]   prev_pix, prev_pix_next;
  logic                          pending, pending_next;

  logic [CW-1:0]                 vx;
  logic                          big;
  logic                          err, err_clamp;
  logic [rvl_pkg::PIX_W-1:0]     cnt, pl_sub, nz_dec;
  logic [rvl_pkg::VALUE_W-1:0]   delta, cur;

  always_comb begin
    vx        = CW'(val);
    big       = vx > CW'(pixels_left);
    cnt       = big ? pixels_left : vx[rvl_pkg::PIX_W-1:0];
    pl_sub    = pixels_left - cnt;
    err       = pending | ovf;
    err_clamp = err | big;
    delta     = vx[rvl_pkg::VALUE_W:1] ^ {rvl_pkg::VALUE_W{vx[0]}};
    cur       = prev_pix + delta;
    nz_dec    = (nz_left != '0) ? nz_left - rvl_pkg::PIX_W'(1) : '0;

    phase_next       = phase;
    pixels_left_next = pixels_left;
    nz_left_next     = nz_left;
    prev_pix_next    = prev_pix;
    pending_next     = pending;
    dec              = '0;

    if (fire) begin
      pending_next = err;
      if (val_done) begin
        case (phase)
          PH_ZERO: begin
            pixels_left_next = pl_sub;
            dec.emit         = (cnt != '0);
            dec.res          = '{pixel_value:  '0,
                                 repeat_count: cnt,
                                 frame_done:   (pl_sub == '0),
                                 format_error: err_clamp};
            pending_next     = dec.emit ? 1'b0 : err_clamp;
            phase_next       = PH_NZ;
          end
          PH_NZ: begin
            pixels_left_next = pl_sub;
            nz_left_next     = cnt;
            pending_next     = err_clamp;
            if (cnt != '0) begin
              phase_next = PH_DELTA;
            end else if (pl_sub == '0) begin
              dec.ended = 1'b1;
            end else begin
              phase_next = PH_ZERO;
            end
          end
          PH_DELTA: begin
            prev_pix_next = cur;
            nz_left_next  = nz_dec;
            dec.emit      = 1'b1;
            dec.res       = '{pixel_value:  cur,
                              repeat_count: rvl_pkg::PIX_W'(1),
                              frame_done:   (nz_dec == '0) && (pixels_left == '0),
                              format_error: err};
            pending_next  = 1'b0;
            if (nz_dec == '0) begin
              if (pixels_left == '0) begin
                dec.ended = 1'b1;
              end else begin
                phase_next = PH_ZERO;
              end
            end
          end
          default: begin
            phase_next = PH_ZERO;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= rvl_pkg::PIXEL_COUNT_RST;
      phase       <= PH_ZERO;
      pixels_left <= rvl_pkg::PIXEL_COUNT_RST;
      nz_left     <= '0;
      prev_pix    <= '0;
      pending     <= 1'b0;
    end else if (cfg_wen) begin
      // new count also restarts at a frame start
      pixel_count <= cfg_wdata;
      phase       <= PH_ZERO;
      pixels_left <= cfg_wdata;
      nz_left     <= '0;
      prev_pix    <= '0;
      pending     <= 1'b0;
    end else if (dec.ended) begin
      phase       <= PH_ZERO;
      pixels_left <= pixel_count;
      nz_left     <= '0;
      prev_pix    <= '0;
      pending     <= 1'b0;
    end else begin
      phase       <= phase_next;
      pixels_left <= pixels_left_next;
      nz_left     <= nz_left_next;
      prev_pix    <= prev_pix_next;
      pending     <= pending_next;
    end
  end

endmodule

/* sv/rvl_depth_decoder_core.sv */
// Top level of the depth decoder: nibble-serial decode with a held result and an output register.
//
// Decodes a run-length / zigzag-delta compressed depth stream. Each accepted
// 32-bit stream_word is shifted out one nibble per cycle, top nibble first,
// except while output back-pressure pauses it; after its nibbles the last
// result is released and then the input stall drops, so a new word is taken
// once all nibbles are done and the last result has moved to the output
// register (a word that yields no result has none to release, and a frame
// end drops the rest of the word). Every result is one run descriptor:
// pixel_value with repeat_count (zero runs carry value 0; each delta pixel is
// a run of one).
// Results are held one deep so the last result of a word can carry word_done;
// when the held result and the output register are both occupied and the
// output is not drained, nibble processing pauses, so output stalls back up
// into the input channel. When a frame's pixels are used up the rest of the
// word is dropped as padding and the decoder returns to a frame start. A cfg_wen
// transfer loads pixel_count and restarts at a frame start; write it only while the block is idle.
`include "rvl_depth_decoder_core_defines.svh"

module rvl_depth_decoder_core #(
  parameter int COUNT_BITS = rvl_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // config
  input  logic                          cfg_wen,
  input  logic [rvl_pkg::PIX_W-1:0]     cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rvl_pkg::WORD_W-1:0]    stream_word,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rvl_pkg::VALUE_W-1:0]   pixel_value,
  output logic [rvl_pkg::PIX_W-1:0]     repeat_count,
  output logic                          word_done,
  output logic                          frame_done,
  output logic                          format_error
);

  logic                          in_xfer;
  logic [rvl_pkg::NIB_W-1:0]     nibble;
  logic                          nib_avail;
  logic                          out_free;
  logic                          fire;
  logic                          finish;
  logic [COUNT_BITS-1:0]         val;
  logic                          val_done;
  logic                          ovf;
  rvl_pkg::dec_out_t             dec;

  // held result: the newest one, waiting to learn whether it ends the word
  rvl_pkg::res_t                 hold;
  logic                          hold_valid;

  // output slot frees up when empty or when its transfer happens now
  assign out_free = !out_valid || !out_stall;

  // a nibble can go only if a result it makes has somewhere to push the held one
  assign fire   = nib_avail && (!hold_valid || out_free);
  // word finished: release the held result with word_done
  assign finish = !nib_avail && hold_valid && out_free;

  assign in_stall = nib_avail || hold_valid;
  assign in_xfer  = in_valid && !in_stall;

  rvl_nibble_sreg u_sreg (
    .clk    (clk),
    .rst    (rst),
    .load   (in_xfer),
    .word   (stream_word),
    .shift  (fire),
    .flush  (fire && dec.ended),
    .nibble (nibble),
    .avail  (nib_avail)
  );

  rvl_value_asm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_asm (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_wen),
    .fire   (fire),
    .nibble (nibble),
    .val    (val),
    .done   (val_done),
    .ovf    (ovf)
  );

  rvl_run_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dec (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .val_done  (val_done),
    .val       (val),
    .ovf       (ovf),
    .dec       (dec)
  );

  // hold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (fire && dec.emit) begin
      hold_valid <= 1'b1;
    end else if (finish) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && dec.emit) begin
      hold <= dec.res;
    end
  end

  // output register; loads the held result when a newer one displaces it
  // (not last of word) or when the word is finished (last of word)
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((fire && dec.emit && hold_valid) || finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((fire && dec.emit && hold_valid) || finish) begin
      pixel_value  <= hold.pixel_value;
      repeat_count <= hold.repeat_count;
      frame_done   <= hold.frame_done;
      format_error <= hold.format_error;
      word_done    <= finish;
    end
  end

  // a descriptor never describes an empty run
  `RVL_ASSERT_NOW(a_run_nonempty, out_valid, repeat_count != '0, "empty run at output")
  // a word transfer arms the nibble shifter on the next cycle
  `RVL_ASSERT_NEXT(a_word_armed, in_xfer, nib_avail, "word accepted but no nibbles")
  // end of frame drops the rest of the word
  `RVL_ASSERT_NEXT(a_pad_drop, fire && dec.ended, !nib_avail, "padding not discarded")
  // closing a word presents a result marked as last of word
  `RVL_ASSERT_NEXT(a_word_close, finish, out_valid && word_done, "word end not marked")

endmodule
